>>> src/vbb_pkg.sv
package vbb_pkg;

    localparam int PROJ_W    = 256;
    localparam int PROJ_H    = 256;
    localparam int FRAC      = 14;
    localparam int STORE_AW  = 16;
    localparam int STORE_D   = 1 << STORE_AW;
    localparam int QDEPTH    = 8;
    localparam int QAW       = $clog2(QDEPTH);
    // Front stages that may hold an item on its way into the queue, plus one
    // transfer being accepted.
    localparam int FRONT_INFLIGHT = 5;

    typedef enum logic [2:0] {
        REG_CXU = 3'd0,
        REG_CYU = 3'd1,
        REG_CZU = 3'd2,
        REG_CXV = 3'd3,
        REG_CYV = 3'd4,
        REG_CTX = 3'd5,
        REG_CTY = 3'd6,
        REG_CTZ = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] cxu;
        logic signed [15:0] cyu;
        logic signed [15:0] czu;
        logic signed [15:0] cxv;
        logic signed [15:0] cyv;
        logic signed [11:0] ctx;
        logic signed [11:0] cty;
        logic signed [11:0] ctz;
    } t_cfg;

    typedef struct packed {
        logic                  is_vox;
        logic                  in_view;
        logic                  last_col;
        logic                  last_row;
        logic [FRAC-1:0]       xd;
        logic [FRAC-1:0]       yd;
        logic [STORE_AW-1:0]   a00;
        logic [STORE_AW-1:0]   a01;
        logic [STORE_AW-1:0]   a10;
        logic [STORE_AW-1:0]   a11;
        logic signed [15:0]    wdata;
        logic signed [31:0]    vin;
    } t_job;

endpackage

>>> src/vbb_ram.sv
module vbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> src/vbb_front.sv
module vbb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_action,
    input  logic [15:0]          i_pixel_index,
    input  logic signed [15:0]   i_pixel_value,
    input  logic [8:0]           i_vox_x,
    input  logic [8:0]           i_vox_y,
    input  logic [8:0]           i_vox_z,
    input  logic signed [31:0]   i_voxel_in,
    input  vbb_pkg::t_cfg        i_cfg,
    output logic                 o_push,
    output vbb_pkg::t_job        o_job
);
    import vbb_pkg::*;

    localparam logic signed [31:0] U_OFF   = 32'((PROJ_W / 2 + 1) << FRAC);
    localparam logic signed [31:0] V_OFF   = 32'((PROJ_H / 2 + 1) << FRAC);
    localparam logic signed [17:0] COL_MAX = 18'(PROJ_W);
    localparam logic signed [17:0] ROW_MAX = 18'(PROJ_H);
    localparam logic [STORE_AW-1:0] W_A    = STORE_AW'(PROJ_W);

    // Stage 0: centred coordinates.
    logic                r_v0, r_act0;
    logic [15:0]         r_idx0;
    logic signed [15:0]  r_pix0;
    logic signed [31:0]  r_vin0;
    logic signed [13:0]  r_dx, r_dy, r_dz;
    // Stage 1: products.
    logic                r_v1, r_act1;
    logic [15:0]         r_idx1;
    logic signed [15:0]  r_pix1;
    logic signed [31:0]  r_vin1;
    logic signed [29:0]  r_pxu, r_pyu, r_pzu, r_pxv, r_pyv;
    // Stage 2: projected position.
    logic                r_v2, r_act2;
    logic [15:0]         r_idx2;
    logic signed [15:0]  r_pix2;
    logic signed [31:0]  r_vin2;
    logic signed [31:0]  r_u, r_v;

    logic signed [17:0]  col, row;
    logic [STORE_AW-1:0] cm1, rm1, base;
    logic                lc, lr, in_view;
    t_job                n_job;

    always_comb begin
        col     = r_u[31:FRAC];
        row     = r_v[31:FRAC];
        in_view = (col >= 18'sd1) && (row >= 18'sd1) && (col <= COL_MAX) && (row <= ROW_MAX);
        lc      = (col == COL_MAX);
        lr      = (row == ROW_MAX);
        cm1     = STORE_AW'(col - 18'sd1);
        rm1     = STORE_AW'(row - 18'sd1);
        base    = rm1 * W_A + cm1;

        n_job          = '0;
        n_job.is_vox   = r_act2;
        n_job.vin      = r_vin2;
        n_job.wdata    = r_pix2;
        n_job.in_view  = in_view;
        n_job.last_col = lc;
        n_job.last_row = lr;
        n_job.xd       = lc ? '0 : r_u[FRAC-1:0];
        n_job.yd       = lr ? '0 : r_v[FRAC-1:0];
        if (r_act2) begin
            n_job.a00 = base;
            n_job.a01 = base + STORE_AW'(1);
            n_job.a10 = base + W_A;
            n_job.a11 = base + W_A + STORE_AW'(1);
        end else begin
            n_job.a00 = r_idx2;
            n_job.a01 = r_idx2;
            n_job.a10 = r_idx2;
            n_job.a11 = r_idx2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_push <= 1'b0;
        end else begin
            r_v0   <= i_take;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            o_push <= r_v2;
        end

        r_act0 <= i_action;
        r_idx0 <= i_pixel_index;
        r_pix0 <= i_pixel_value;
        r_vin0 <= i_voxel_in;
        r_dx   <= $signed({5'b0, i_vox_x}) - 14'(i_cfg.ctx);
        r_dy   <= $signed({5'b0, i_vox_y}) - 14'(i_cfg.cty);
        r_dz   <= $signed({5'b0, i_vox_z}) - 14'(i_cfg.ctz);

        r_act1 <= r_act0;
        r_idx1 <= r_idx0;
        r_pix1 <= r_pix0;
        r_vin1 <= r_vin0;
        r_pxu  <= r_dx * i_cfg.cxu;
        r_pyu  <= r_dy * i_cfg.cyu;
        r_pzu  <= r_dz * i_cfg.czu;
        r_pxv  <= r_dx * i_cfg.cxv;
        r_pyv  <= r_dy * i_cfg.cyv;

        r_act2 <= r_act1;
        r_idx2 <= r_idx1;
        r_pix2 <= r_pix1;
        r_vin2 <= r_vin1;
        r_u    <= 32'(r_pxu) + 32'(r_pyu) + 32'(r_pzu) + U_OFF;
        r_v    <= 32'(r_pxv) + 32'(r_pyv) + V_OFF;

        o_job  <= n_job;
    end
endmodule

>>> src/vbb_queue.sv
module vbb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vbb_pkg::t_job   i_job,
    output logic            o_valid,
    output vbb_pkg::t_job   o_job,
    output logic            o_nearly_full
);
    import vbb_pkg::*;

    t_job           r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    // The back end drains one entry every cycle, so an entry leaves whenever
    // there is one.
    assign o_valid       = (r_cnt != '0);
    assign o_job         = r_q[r_rp];
    assign o_nearly_full = (r_cnt > (QAW + 1)'(QDEPTH - FRONT_INFLIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (o_valid) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW + 1)'(i_push) - (QAW + 1)'(o_valid);
        end
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end
endmodule

>>> src/vbb_back.sv
module vbb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  vbb_pkg::t_job       i_job,
    output logic                o_strobe,
    output logic signed [31:0]  o_voxel_out,
    output logic                o_inside_res
);
    import vbb_pkg::*;

    logic                we;
    logic [15:0]         q00, q01, q10, q11;

    assign we = i_valid && !i_job.is_vox;

    // Four copies of the projection, so that all four neighbours come out in
    // the same cycle. Loads and reads pass this stage in order, so no hazard arises.
    vbb_ram #(.WIDTH(16), .DEPTH(STORE_D)) u_ram00 (
        .i_clk(i_clk), .i_we(we), .i_addr(i_job.a00), .i_wdata(i_job.wdata), .o_rdata(q00));
    vbb_ram #(.WIDTH(16), .DEPTH(STORE_D)) u_ram01 (
        .i_clk(i_clk), .i_we(we), .i_addr(i_job.a01), .i_wdata(i_job.wdata), .o_rdata(q01));
    vbb_ram #(.WIDTH(16), .DEPTH(STORE_D)) u_ram10 (
        .i_clk(i_clk), .i_we(we), .i_addr(i_job.a10), .i_wdata(i_job.wdata), .o_rdata(q10));
    vbb_ram #(.WIDTH(16), .DEPTH(STORE_D)) u_ram11 (
        .i_clk(i_clk), .i_we(we), .i_addr(i_job.a11), .i_wdata(i_job.wdata), .o_rdata(q11));

    // Stage 1: memory data arrives.
    logic                r_v1, r_in1, r_lc1, r_lr1;
    logic [FRAC-1:0]     r_xd1, r_yd1;
    logic signed [31:0]  r_vin1;
    // Stage 2: row interpolations.
    logic                r_v2, r_in2;
    logic [FRAC-1:0]     r_yd2;
    logic signed [31:0]  r_vin2, r_r1, r_r2;
    // Stage 3: column interpolation.
    logic                r_v3, r_in3;
    logic signed [31:0]  r_vin3;
    logic signed [47:0]  r_acc;

    logic signed [16:0]  p00, p01, p10, p11;
    logic signed [31:0]  n_r1, n_r2;
    logic signed [14:0]  xs, ys;
    logic signed [32:0]  dr;
    logic signed [47:0]  n_acc, rnd;
    logic signed [19:0]  sample;
    logic signed [32:0]  sum;
    logic signed [31:0]  n_out;

    always_comb begin
        // Neighbours beyond the last column or row are masked to zero.
        p00  = 17'($signed(q00));
        p01  = r_lc1 ? 17'sd0 : 17'($signed(q01));
        p10  = r_lr1 ? 17'sd0 : 17'($signed(q10));
        p11  = (r_lr1 || r_lc1) ? 17'sd0 : 17'($signed(q11));
        xs   = $signed({1'b0, r_xd1});
        n_r1 = (32'(p00) <<< FRAC) + 32'(p01 - p00) * 32'(xs);
        n_r2 = (32'(p10) <<< FRAC) + 32'(p11 - p10) * 32'(xs);

        ys    = $signed({1'b0, r_yd2});
        dr    = 33'(r_r2) - 33'(r_r1);
        n_acc = (48'(r_r1) <<< FRAC) + 48'(dr) * 48'(ys);

        rnd    = r_acc + 48'sd134217728;
        sample = rnd[47:28];
        sum    = 33'(r_vin3) + 33'(sample);
        if (!r_in3) begin
            n_out = r_vin3;
        end else if (sum > 33'sd2147483647) begin
            n_out = 32'sh7fffffff;
        end else if (sum < -33'sd2147483648) begin
            n_out = 32'sh80000000;
        end else begin
            n_out = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_v1     <= i_valid && i_job.is_vox;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            o_strobe <= r_v3;
        end

        r_in1  <= i_job.in_view;
        r_lc1  <= i_job.last_col;
        r_lr1  <= i_job.last_row;
        r_xd1  <= i_job.xd;
        r_yd1  <= i_job.yd;
        r_vin1 <= i_job.vin;

        r_in2  <= r_in1;
        r_yd2  <= r_yd1;
        r_vin2 <= r_vin1;
        r_r1   <= n_r1;
        r_r2   <= n_r2;

        r_in3  <= r_in2;
        r_vin3 <= r_vin2;
        r_acc  <= n_acc;

        o_voxel_out  <= n_out;
        o_inside_res <= r_in3;
    end
endmodule

>>> src/voxel_backprojection_bilinear_unit.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------
// input    | start & !busy         | i_action, i_pixel_index, i_pixel_value,
//          |                       | i_vox_x/y/z, i_voxel_in
// result   | o_strobe (one cycle)  | o_voxel_out, o_inside_res
// config   | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One transfer per cycle is accepted while busy is low. A voxel's result passes
// four front stages, one queue slot and four back stages on its way to the result
// ports, the first of them loaded at the transfer edge itself.
// The back end reads all four neighbours in the same cycle from four copies of
// the projection store. Loads give no result.
// Reset is synchronous and active low and restores the default registers.
// The receiver cannot stall; busy rises when the queue holds over three entries.
module voxel_backprojection_bilinear_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [15:0]         i_pixel_index,
    input  logic signed [15:0]  i_pixel_value,
    input  logic [8:0]          i_vox_x,
    input  logic [8:0]          i_vox_y,
    input  logic [8:0]          i_vox_z,
    input  logic signed [31:0]  i_voxel_in,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic                o_strobe,
    output logic signed [31:0]  o_voxel_out,
    output logic                o_inside_res
);
    import vbb_pkg::*;

    t_cfg  r_cfg;
    logic  take, push, qv, nfull;
    t_job  f_job, q_job;

    assign busy = nfull;
    assign take = start && !nfull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cxu <= 16'sd16384;
            r_cfg.cyu <= 16'sd0;
            r_cfg.czu <= 16'sd0;
            r_cfg.cxv <= 16'sd0;
            r_cfg.cyv <= 16'sd16384;
            r_cfg.ctx <= 12'sd129;
            r_cfg.cty <= 12'sd129;
            r_cfg.ctz <= 12'sd129;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CXU: r_cfg.cxu <= i_cfg_data;
                REG_CYU: r_cfg.cyu <= i_cfg_data;
                REG_CZU: r_cfg.czu <= i_cfg_data;
                REG_CXV: r_cfg.cxv <= i_cfg_data;
                REG_CYV: r_cfg.cyv <= i_cfg_data;
                REG_CTX: r_cfg.ctx <= i_cfg_data[11:0];
                REG_CTY: r_cfg.cty <= i_cfg_data[11:0];
                REG_CTZ: r_cfg.ctz <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    vbb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_action(i_action),
        .i_pixel_index(i_pixel_index), .i_pixel_value(i_pixel_value),
        .i_vox_x(i_vox_x), .i_vox_y(i_vox_y), .i_vox_z(i_vox_z),
        .i_voxel_in(i_voxel_in), .i_cfg(r_cfg), .o_push(push), .o_job(f_job)
    );

    vbb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(f_job),
        .o_valid(qv), .o_job(q_job), .o_nearly_full(nfull)
    );

    vbb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qv), .i_job(q_job),
        .o_strobe(o_strobe), .o_voxel_out(o_voxel_out), .o_inside_res(o_inside_res)
    );
endmodule

>>> test/voxel_backprojection_bilinear_unit_test.sv
module voxel_backprojection_bilinear_unit_test;
    import vbb_pkg::*;

    typedef struct {
        logic signed [31:0] voxel_out;
        logic               in_view;
    } t_voxel_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_action;
    logic [15:0]        i_pixel_index;
    logic signed [15:0] i_pixel_value;
    logic [8:0]         i_vox_x;
    logic [8:0]         i_vox_y;
    logic [8:0]         i_vox_z;
    logic signed [31:0] i_voxel_in;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               o_strobe;
    logic signed [31:0] o_voxel_out;
    logic               o_inside_res;

    t_cfg               geom;
    logic signed [15:0] proj_image [STORE_D];
    bit                 pixel_loaded [STORE_D];
    t_voxel_result      pending_voxels [$];
    int                 error_count;
    int                 burst_left;

    voxel_backprojection_bilinear_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_pixel_index (i_pixel_index),
        .i_pixel_value (i_pixel_value),
        .i_vox_x       (i_vox_x),
        .i_vox_y       (i_vox_y),
        .i_vox_z       (i_vox_z),
        .i_voxel_in    (i_voxel_in),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_voxel_out   (o_voxel_out),
        .o_inside_res  (o_inside_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Projects a voxel onto the image: 1-based column and row plus Q.14 fractions.
    function automatic void project_voxel(input logic [8:0] x, y, z,
                                          output longint col, row, xd, yd);
        longint dx, dy, dz, u, v;
        dx = longint'(x) - longint'(geom.ctx);
        dy = longint'(y) - longint'(geom.cty);
        dz = longint'(z) - longint'(geom.ctz);
        u = dx * geom.cxu + dy * geom.cyu + dz * geom.czu + longint'(PROJ_W / 2 + 1) * 16384;
        v = dx * geom.cxv + dy * geom.cyv + longint'(PROJ_H / 2 + 1) * 16384;
        col = u >>> FRAC;
        row = v >>> FRAC;
        xd = u - col * 16384;
        yd = v - row * 16384;
    endfunction

    function automatic bit is_inside(input longint col, row);
        return col >= 1 && row >= 1 && col <= PROJ_W && row <= PROJ_H;
    endfunction

    function automatic t_voxel_result interpolate_voxel(input logic [8:0] x, y, z,
                                                        input logic signed [31:0] vin);
        t_voxel_result r;
        longint col, row, xd, yd, base, p00, p01, p10, p11, r1, r2, acc, total;
        project_voxel(x, y, z, col, row, xd, yd);
        if (!is_inside(col, row)) begin
            r.voxel_out = vin;
            r.in_view = 1'b0;
            return r;
        end
        base = (row - 1) * PROJ_W + (col - 1);
        p00 = proj_image[base & 16'hFFFF];
        p01 = 0;
        if (col == PROJ_W) xd = 0;
        else p01 = proj_image[(base + 1) & 16'hFFFF];
        r1 = p00 * 16384 + (p01 - p00) * xd;
        if (row == PROJ_H) begin
            yd = 0;
            r2 = 0;
        end else begin
            p10 = proj_image[(base + PROJ_W) & 16'hFFFF];
            p11 = 0;
            if (col != PROJ_W) p11 = proj_image[(base + PROJ_W + 1) & 16'hFFFF];
            r2 = p10 * 16384 + (p11 - p10) * xd;
        end
        acc = r1 * 16384 + (r2 - r1) * yd;
        total = longint'(vin) + ((acc + (64'sd1 <<< 27)) >>> 28);
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        r.voxel_out = total[31:0];
        r.in_view = 1'b1;
        return r;
    endfunction

    // Drops start and then waits; every pause between transfers goes through here.
    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drives one item and returns at the edge of its transfer, with start still high.
    task automatic send_item(input logic act, input logic [15:0] idx, input logic signed [15:0] pix,
                             input logic [8:0] x, y, z, input logic signed [31:0] vin);
        bit stalled;
        if (burst_left == 0) begin
            pause($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start         <= 1'b1;
        i_action      <= act;
        i_pixel_index <= idx;
        i_pixel_value <= pix;
        i_vox_x       <= x;
        i_vox_y       <= y;
        i_vox_z       <= z;
        i_voxel_in    <= vin;
        // Busy is taken from the middle of the cycle, so it is the value seen at the edge.
        forever begin
            @(negedge i_clk);
            stalled = busy;
            @(posedge i_clk);
            if (!stalled) break;
        end
        if (act) pending_voxels.push_back(interpolate_voxel(x, y, z, vin));
        else begin
            proj_image[idx]   = pix;
            pixel_loaded[idx] = 1'b1;
        end
    endtask

    task automatic load_pixel(input logic [15:0] idx, input logic signed [15:0] pix);
        send_item(1'b0, idx, pix, 9'($urandom), 9'($urandom), 9'($urandom), $urandom);
    endtask

    // Any neighbour never loaded gets a random sample first, so no undefined entry is read.
    task automatic send_voxel(input logic [8:0] x, y, z, input logic signed [31:0] vin);
        longint col, row, xd, yd, base;
        logic [15:0] addr [4];
        project_voxel(x, y, z, col, row, xd, yd);
        if (is_inside(col, row)) begin
            base = (row - 1) * PROJ_W + (col - 1);
            addr[0] = 16'(base);
            addr[1] = 16'(base + 1);
            addr[2] = 16'(base + PROJ_W);
            addr[3] = 16'(base + PROJ_W + 1);
            for (int k = 0; k < 4; k++) begin
                if ((k[0] && col == PROJ_W) || (k[1] && row == PROJ_H)) continue;
                if (!pixel_loaded[addr[k]]) load_pixel(addr[k], 16'($urandom));
            end
        end
        send_item(1'b1, 16'($urandom), 16'($urandom), x, y, z, vin);
    endtask

    // Results drain first; loads give no result, so extra cycles cover any still in flight.
    task automatic drain();
        int waited;
        waited = 0;
        pause(1);
        while (pending_voxels.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CXU: geom.cxu = data;
            REG_CYU: geom.cyu = data;
            REG_CZU: geom.czu = data;
            REG_CXV: geom.cxv = data;
            REG_CYV: geom.cyv = data;
            REG_CTX: geom.ctx = data[11:0];
            REG_CTY: geom.cty = data[11:0];
            REG_CTZ: geom.ctz = data[11:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [15:0] cxu, cyu, czu, cxv, cyv, ctx, cty, ctz);
        write_reg(REG_CXU, cxu);
        write_reg(REG_CYU, cyu);
        write_reg(REG_CZU, czu);
        write_reg(REG_CXV, cxv);
        write_reg(REG_CYV, cyv);
        write_reg(REG_CTX, ctx);
        write_reg(REG_CTY, cty);
        write_reg(REG_CTZ, ctz);
    endtask

    always @(posedge i_clk) begin
        t_voxel_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_voxels.size() == 0) begin
                report_mismatch("unexpected result", o_voxel_out, 0);
            end else begin
                want = pending_voxels.pop_front();
                if (o_voxel_out !== want.voxel_out)
                    report_mismatch("voxel_out", o_voxel_out, want.voxel_out);
                if (o_inside_res !== want.in_view)
                    report_mismatch("inside_res", o_inside_res, want.in_view);
            end
        end
    end

    // Identity geometry maps voxel (x, y) straight onto pixel (x, y).
    task automatic test_default_mapping();
        load_pixel(16'h0000, 16'sh7FFF);
        load_pixel(16'hFFFF, -16'sh8000);
        send_voxel(9'd1, 9'd1, 9'd1, 32'sd0);
        send_voxel(9'd256, 9'd256, 9'd256, 32'sh7FFFFFFF);
        send_voxel(9'd256, 9'd1, 9'd17, -32'sd5);
        send_voxel(9'd3, 9'd256, 9'd200, 32'sd100);
        send_voxel(9'd0, 9'd5, 9'd1, 32'sd12);
        send_voxel(9'd257, 9'd5, 9'd1, -32'sd12);
        send_voxel(9'd5, 9'd0, 9'd1, 32'sd7);
        send_voxel(9'd5, 9'd511, 9'd511, -32'sh80000000);
        send_voxel(9'd128, 9'd128, 9'd128, 32'sd1);
    endtask

    task automatic test_saturation();
        load_pixel(16'd257, 16'sh7FFF);
        load_pixel(16'd514, -16'sh8000);
        send_voxel(9'd2, 9'd2, 9'd9, 32'sh7FFFFFFF);
        send_voxel(9'd3, 9'd3, 9'd9, -32'sh80000000);
        send_voxel(9'd2, 9'd2, 9'd9, -32'sh80000000);
        send_voxel(9'd3, 9'd3, 9'd9, 32'sh7FFFFFFF);
    endtask

    // Half-pixel steps and two other geometries test the fractions and edge neighbours.
    task automatic test_fractions();
        set_geometry(16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd8192, 16'sd1, 16'sd1, 16'sd1);
        send_voxel(9'd2, 9'd2, 9'd1, 32'sd0);
        send_voxel(9'd256, 9'd3, 9'd1, 32'sd0);
        send_voxel(9'd511, 9'd511, 9'd1, 32'sd0);
        set_geometry(-16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384,
                     -16'sd1024, 16'sd1024, -16'sd1024);
        send_voxel(9'd1, 9'd1, 9'd1, 32'sd3);
        send_voxel(9'd256, 9'd256, 9'd256, 32'sd3);
        set_geometry(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8001, 16'h7FFF,
                     16'h0FFF, 16'h0800, 16'hF7FF);
        send_voxel(9'd100, 9'd200, 9'd50, 32'sd0);
    endtask

    task automatic randomise_geometry();
        logic [15:0] c [8];
        for (int k = 0; k < 5; k++)
            c[k] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
        for (int k = 5; k < 8; k++)
            c[k] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300) - 20);
        set_geometry(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    task automatic test_random_traffic();
        logic [8:0] x, y, z;
        for (int phase = 0; phase < 6; phase++) begin
            randomise_geometry();
            for (int n = 0; n < 110; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    load_pixel(16'($urandom), 16'($urandom));
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        x = 9'($urandom);
                        y = 9'($urandom);
                        z = 9'($urandom);
                    end else begin
                        x = 9'($urandom_range(1, 256));
                        y = 9'($urandom_range(1, 256));
                        z = 9'($urandom_range(1, 256));
                    end
                    send_voxel(x, y, z, ($urandom_range(0, 5) == 0) ?
                               ($urandom_range(0, 1) ? 32'sh7FFFFFF0 : -32'sh7FFFFFF0) + $urandom_range(0, 31)
                               : $urandom);
                end
                // In odd phases, gaps come only between items of one send_voxel call.
                if (phase % 2 == 1) burst_left = 1;
            end
        end
    endtask

    initial begin
        error_count   = 0;
        burst_left    = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_action      = 1'b0;
        i_pixel_index = '0;
        i_pixel_value = '0;
        i_vox_x       = '0;
        i_vox_y       = '0;
        i_vox_z       = '0;
        i_voxel_in    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_CXU;
        i_cfg_data    = '0;
        geom = '{cxu: 16'sd16384, cyu: 16'sd0, czu: 16'sd0, cxv: 16'sd0, cyv: 16'sd16384,
                 ctx: 12'sd129, cty: 12'sd129, ctz: 12'sd129};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_mapping();
        test_saturation();
        test_fractions();
        test_random_traffic();
        drain();

        if (error_count == 0 && pending_voxels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
